@@ rtl/core/htkv_pkg.sv @@
// shared types, constants and helpers for the hash table key-value store
package htkv_pkg;

    localparam int NUM_BUCKETS_DEF = 256;
    localparam int WAYS_DEF        = 4;
    localparam int KEY_BYTES_DEF   = 8;
    localparam int VALUE_BYTES_DEF = 8;
    localparam int HASH_SHIFT      = 5;
    localparam int CFG_W           = 9;
    localparam logic [CFG_W-1:0] BUCKETS_RESET = 9'd256;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_UPDATE = 2'd2,
        CMD_DELETE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_ABSENT  = 2'd1,
        ST_PRESENT = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] key;
        logic [3:0]  key_length;
        logic [63:0] value;
        logic [3:0]  value_length;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] found_value;
        logic [3:0]  found_value_length;
        logic [10:0] stored_entries;
    } rsp_t;

    // hash unit to core handoff
    typedef struct packed {
        logic        valid;
        logic [31:0] hash;
    } hash_ctl_t;

    // mask of the low len bytes of a 64-bit word
    function automatic logic [63:0] byte_mask(input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < len) begin
                m[i*8 +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

endpackage

@@ rtl/core/hash_table_key_value_store_core.sv @@
// top level of the hash table key-value store
// Bucketed key-value store: each bucket holds WAYS slots in one wide memory
// row (key, lengths, value); the valid bits and the bucket fill sit in a
// second memory, one word per bucket, that a clearing pass after reset
// empties, and no transfer is taken until that pass ends.
// A request runs through the hash unit (one key byte per cycle, a switch-over
// step, then one remainder bit per cycle over the 32-bit hash), then reads the
// bucket row, compares and writes back, and loads the output register. The
// next request is taken only once the result is loaded, so requests are
// handled one at a time. A result held by out_stall keeps its payload; the
// next request still runs and waits in its last step until the output
// register is free. The bucket count register is written through its own
// valid/ready port; zero acts as 1 and values above NUM_BUCKETS act as
// NUM_BUCKETS.
module hash_table_key_value_store_core
    import htkv_pkg::*;
#(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
    parameter int WAYS        = WAYS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  req_t             in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output rsp_t             out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int BIDX_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FILL_W = $clog2(WAYS + 1);

    // one slot of a bucket row
    typedef struct packed {
        logic [63:0] key;
        logic [3:0]  klen;
        logic [63:0] val;
        logic [3:0]  vlen;
    } slot_t;

    // per-bucket valid bits and fill count
    typedef struct packed {
        logic [WAYS-1:0]   vld;
        logic [FILL_W-1:0] fill;
    } ctl_t;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_HASH  = 6'b000100,
        S_READ  = 6'b001000,
        S_EXEC  = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [BIDX_W-1:0] clr_reg;

    // configuration register
    logic [CFG_W-1:0] buckets_reg;
    logic [CFG_W-1:0] modulus;

    // latched request, masked to its lengths
    logic [1:0]  cmd_reg;
    logic [63:0] key_reg;
    logic [3:0]  klen_reg;
    logic [63:0] val_reg;
    logic [3:0]  vlen_reg;
    logic [3:0]  klen_sat, vlen_sat;
    logic [BIDX_W-1:0] bidx_reg;

    // bucket memories
    slot_t mem [NUM_BUCKETS][WAYS];
    slot_t row_q [WAYS];
    ctl_t  ctl_mem [NUM_BUCKETS];
    ctl_t  ctl_q;
    logic [10:0] total_reg;

    // result held from execute until the output register is free
    rsp_t rsp_reg;

    // output register
    logic out_valid_reg;
    rsp_t out_reg;

    // hash unit
    logic hash_done;
    logic [BIDX_W-1:0] hash_bucket;

    // row lookup
    logic [WAYS-1:0] vrow;
    logic found, have_free;
    logic [WAY_W-1:0] hit_way, free_way;
    logic do_write;
    logic [WAY_W-1:0] wr_way;
    slot_t wr_slot;
    logic ctl_write;
    ctl_t ctl_wr;
    rsp_t rsp;

    assign klen_sat = (in_data.key_length > 4'(KEY_BYTES_DEF)) ? 4'(KEY_BYTES_DEF)
                                                                : in_data.key_length;
    assign vlen_sat = (in_data.value_length > 4'(VALUE_BYTES_DEF)) ? 4'(VALUE_BYTES_DEF)
                                                                    : in_data.value_length;

    always_comb
    begin
        if (buckets_reg == '0)
            modulus = CFG_W'(1);
        else if (32'(buckets_reg) > NUM_BUCKETS)
            modulus = CFG_W'(NUM_BUCKETS);
        else
            modulus = buckets_reg;
    end

    // config writes only while nothing is in flight
    assign cfg_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    htkv_hash #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .BIDX_W      (BIDX_W)
    ) u_hash (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_valid && !in_stall),
        .key        (in_data.key & byte_mask(klen_sat)),
        .key_length (klen_sat),
        .modulus    (modulus),
        .done       (hash_done),
        .bucket     (hash_bucket)
    );

    // compare all ways of the registered row
    always_comb
    begin
        vrow      = ctl_q.vld;
        found     = 1'b0;
        have_free = 1'b0;
        hit_way   = '0;
        free_way  = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (vrow[w]) begin
                if (!found && row_q[w].klen == klen_reg && row_q[w].key == key_reg) begin
                    found   = 1'b1;
                    hit_way = WAY_W'(w);
                end
            end
            else if (!have_free) begin
                have_free = 1'b1;
                free_way  = WAY_W'(w);
            end
        end
    end

    always_comb
    begin
        rsp       = '0;
        do_write  = 1'b0;
        wr_way    = hit_way;
        wr_slot   = '{key: key_reg, klen: klen_reg, val: val_reg, vlen: vlen_reg};
        ctl_write = 1'b0;
        ctl_wr    = ctl_q;
        case (cmd_reg)
            CMD_INSERT:
            begin
                if (found)
                    rsp.status = ST_PRESENT;
                else if (!have_free)
                    rsp.status = ST_FULL;
                else
                begin
                    do_write          = 1'b1;
                    wr_way            = free_way;
                    ctl_write         = 1'b1;
                    ctl_wr.vld[free_way] = 1'b1;
                    ctl_wr.fill       = ctl_q.fill + FILL_W'(1);
                end
            end
            CMD_SEARCH:
            begin
                if (found)
                begin
                    rsp.found_value        = row_q[hit_way].val;
                    rsp.found_value_length = row_q[hit_way].vlen;
                end
                else
                    rsp.status = ST_ABSENT;
            end
            CMD_UPDATE:
            begin
                if (found)
                    do_write = 1'b1;
                else
                    rsp.status = ST_ABSENT;
            end
            default:
            begin
                if (!found)
                    rsp.status = ST_ABSENT;
                else
                begin
                    ctl_write           = 1'b1;
                    ctl_wr.vld[hit_way] = 1'b0;
                    if (ctl_q.fill != '0)
                        ctl_wr.fill = ctl_q.fill - FILL_W'(1);
                end
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_reg == BIDX_W'(NUM_BUCKETS - 1)) state_next = S_IDLE;
            S_IDLE: if (in_valid) state_next = S_HASH;
            S_HASH: if (hash_done) state_next = S_READ;
            S_READ: state_next = S_EXEC;
            S_EXEC: state_next = S_OUT;
            S_OUT:  if (!out_valid_reg || !out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            buckets_reg   <= BUCKETS_RESET;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + BIDX_W'(1);
            if (cfg_valid && cfg_ready)
                buckets_reg <= cfg_data;
            if (state_reg == S_OUT && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (state_reg == S_EXEC)
            begin
                if (cmd_reg == CMD_INSERT && !found && have_free)
                    total_reg <= total_reg + 11'd1;
                else if (cmd_reg == CMD_DELETE && found && total_reg != '0)
                    total_reg <= total_reg - 11'd1;
            end
        end
    end

    // request capture, bucket index, result payload
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            cmd_reg  <= in_data.cmd;
            key_reg  <= in_data.key & byte_mask(klen_sat);
            klen_reg <= klen_sat;
            val_reg  <= in_data.value & byte_mask(vlen_sat);
            vlen_reg <= vlen_sat;
        end
        if (hash_done)
            bidx_reg <= hash_bucket;
        if (state_reg == S_EXEC)
            rsp_reg <= rsp;
        if (state_reg == S_OUT && (!out_valid_reg || !out_stall))
            out_reg <= '{status:             rsp_reg.status,
                         found_value:        rsp_reg.found_value,
                         found_value_length: rsp_reg.found_value_length,
                         stored_entries:     total_reg};
    end

    // bucket memories: one registered read, one write
    always_ff @(posedge clk)
    begin
        for (int w = 0; w < WAYS; w++) begin
            row_q[w] <= mem[bidx_reg][w];
        end
        ctl_q <= ctl_mem[bidx_reg];
        if (state_reg == S_EXEC && do_write)
            mem[bidx_reg][wr_way] <= wr_slot;
        if (state_reg == S_CLEAR)
            ctl_mem[clr_reg] <= '0;
        else if (state_reg == S_EXEC && ctl_write)
            ctl_mem[bidx_reg] <= ctl_wr;
    end

    // outside an execute, the stored total moves by at most one
    a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_EXEC |=> (total_reg == $past(total_reg)
            || total_reg == $past(total_reg) + 11'd1
            || total_reg == $past(total_reg) - 11'd1))
        else $error("entry total moved by more than one");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> in_stall)
        else $error("input accepted while busy");

    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> (state_reg == S_IDLE && !out_valid_reg))
        else $error("config open while a request is in flight");

    a_exec_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |=> state_reg == S_EXEC)
        else $error("row read not followed by execute");

endmodule

@@ rtl/core/htkv_hash.sv @@
// iterative key hash and modulo reduction unit
module htkv_hash
    import htkv_pkg::*;
#(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
    parameter int BIDX_W      = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [63:0]       key,
    input  logic [3:0]        key_length,
    input  logic [CFG_W-1:0]  modulus,
    output logic              done,
    output logic [BIDX_W-1:0] bucket
);

    typedef enum logic [2:0] {
        H_IDLE = 3'b001,
        H_HASH = 3'b010,
        H_MOD  = 3'b100
    } hstate_t;

    hstate_t      state_reg, state_next;
    logic [31:0]  h_reg, h_next;
    logic [63:0]  key_reg, key_next;
    logic [3:0]   cnt_reg, cnt_next;
    logic [5:0]   bit_reg, bit_next;
    logic [CFG_W-1:0] rem_reg, rem_next;
    logic [CFG_W:0]   trial;

    // restoring remainder, one bit per cycle, 9-bit divisor
    assign trial = {rem_reg, h_reg[5'(bit_reg)]} - {1'b0, modulus};

    always_comb
    begin
        state_next = state_reg;
        h_next     = h_reg;
        key_next   = key_reg;
        cnt_next   = cnt_reg;
        bit_next   = bit_reg;
        rem_next   = rem_reg;
        done       = 1'b0;
        unique case (state_reg)
            H_IDLE:
            begin
                if (start)
                begin
                    h_next     = '0;
                    key_next   = key;
                    cnt_next   = key_length;
                    state_next = H_HASH;
                end
            end
            H_HASH:
            begin
                if (cnt_reg == 4'd0)
                begin
                    bit_next   = 6'd31;
                    rem_next   = '0;
                    state_next = H_MOD;
                end
                else
                begin
                    h_next   = (h_reg << HASH_SHIFT) + {24'd0, key_reg[7:0]};
                    key_next = key_reg >> 8;
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            H_MOD:
            begin
                if (trial[CFG_W])
                    rem_next = CFG_W'({rem_reg, h_reg[5'(bit_reg)]});
                else
                    rem_next = trial[CFG_W-1:0];
                bit_next = bit_reg - 6'd1;
                if (bit_reg == 6'd0)
                begin
                    done       = 1'b1;
                    state_next = H_IDLE;
                end
            end
            default: state_next = H_IDLE;
        endcase
    end

    assign bucket = BIDX_W'(rem_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= H_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        h_reg   <= h_next;
        key_reg <= key_next;
        cnt_reg <= cnt_next;
        bit_reg <= bit_next;
        rem_reg <= rem_next;
    end

endmodule

@@ tb/sv/tb_top.sv @@
// testbench of the hash table key-value store: directed table plus random traffic
`timescale 1ns / 100ps

module tb_top;
    import htkv_pkg::*;

    localparam int N_BUCKETS  = 256;
    localparam int N_WAYS     = 4;
    localparam int N_SLOTS    = N_BUCKETS * N_WAYS;
    localparam int STALL_PCT  = 12;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_WAIT = 60;
    localparam int PHASE_LEN  = 170;
    localparam int POOL_SIZE  = 24;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    req_t in_data;
    logic out_valid;
    logic out_stall;
    rsp_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    hash_table_key_value_store_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 2 ns clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // predictor copy of the table contents
    bit          tbl_valid [N_SLOTS];
    logic [63:0] tbl_key   [N_SLOTS];
    logic [3:0]  tbl_klen  [N_SLOTS];
    logic [63:0] tbl_val   [N_SLOTS];
    logic [3:0]  tbl_vlen  [N_SLOTS];
    int unsigned tbl_count;
    logic [CFG_W-1:0] bucket_mod;

    rsp_t pending_rsp[$];
    int   error_count = 0;
    int   idle_cycles = 0;
    bit   quiet;

    // low len bytes set
    function automatic logic [63:0] len_mask(input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (i < len) begin
                m[8*i +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

    // work out the response to one request and update the table copy
    function automatic rsp_t kv_lookup_update(input req_t r);
        rsp_t        rsp;
        logic [3:0]  kl;
        logic [3:0]  vl;
        logic [63:0] k;
        logic [63:0] v;
        logic [31:0] h;
        int unsigned m;
        int unsigned base;
        int          hit;
        int          free_slot;
        kl = (r.key_length > 4'd8) ? 4'd8 : r.key_length;
        vl = (r.value_length > 4'd8) ? 4'd8 : r.value_length;
        k = r.key & len_mask(kl);
        v = r.value & len_mask(vl);
        h = '0;
        for (int i = 0; i < kl; i++) begin
            h = (h << 5) + 32'(k[8*i +: 8]);
        end
        m = bucket_mod;
        if (m == 0) m = 1;
        if (m > N_BUCKETS) m = N_BUCKETS;
        base = (h % m) * N_WAYS;
        hit = -1;
        free_slot = -1;
        // first matching way, lowest free way
        for (int w = 0; w < N_WAYS; w++) begin
            if (tbl_valid[base + w]) begin
                if (hit < 0 && tbl_klen[base + w] == kl && tbl_key[base + w] == k) begin
                    hit = base + w;
                end
            end else if (free_slot < 0) begin
                free_slot = base + w;
            end
        end
        rsp = '0;
        rsp.status = ST_DONE;
        case (cmd_t'(r.cmd))
            CMD_INSERT: begin
                if (hit >= 0) begin
                    rsp.status = ST_PRESENT;
                end else if (free_slot < 0) begin
                    rsp.status = ST_FULL;
                end else begin
                    tbl_valid[free_slot] = 1'b1;
                    tbl_key[free_slot]   = k;
                    tbl_klen[free_slot]  = kl;
                    tbl_val[free_slot]   = v;
                    tbl_vlen[free_slot]  = vl;
                    tbl_count++;
                end
            end
            CMD_SEARCH: begin
                if (hit >= 0) begin
                    rsp.found_value        = tbl_val[hit];
                    rsp.found_value_length = tbl_vlen[hit];
                end else begin
                    rsp.status = ST_ABSENT;
                end
            end
            CMD_UPDATE: begin
                if (hit >= 0) begin
                    tbl_val[hit]  = v;
                    tbl_vlen[hit] = vl;
                end else begin
                    rsp.status = ST_ABSENT;
                end
            end
            default: begin
                if (hit >= 0) begin
                    tbl_valid[hit] = 1'b0;
                    if (tbl_count > 0) tbl_count--;
                end else begin
                    rsp.status = ST_ABSENT;
                end
            end
        endcase
        rsp.stored_entries = 11'(tbl_count);
        return rsp;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // response checker
    always @(posedge clk) begin
        rsp_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_rsp.size() == 0) begin
                report_mismatch("unexpected response", 64'(out_data), 64'd0);
            end else begin
                want = pending_rsp.pop_front();
                if (out_data.status !== want.status)
                    report_mismatch("status", 64'(out_data.status), 64'(want.status));
                if (out_data.found_value !== want.found_value)
                    report_mismatch("found_value", out_data.found_value, want.found_value);
                if (out_data.found_value_length !== want.found_value_length)
                    report_mismatch("found_value_length", 64'(out_data.found_value_length),
                                    64'(want.found_value_length));
                if (out_data.stored_entries !== want.stored_entries)
                    report_mismatch("stored_entries", 64'(out_data.stored_entries),
                                    64'(want.stored_entries));
            end
        end
    end

    // receiver back-pressure, changed on the falling edge
    always @(negedge clk) begin
        out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < STALL_PCT);
    end

    // watchdog: cycles with no transfer on any channel
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // one request transfer; the expectation is queued when it is taken
    task automatic send_req(input req_t r, input bit typed, input rsp_t typed_rsp);
        rsp_t pred;
        if (!quiet && $urandom_range(0, 99) < STALL_PCT) begin
            repeat ($urandom_range(1, 6)) begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= r;
        do @(posedge clk); while (in_stall !== 1'b0);
        pred = kv_lookup_update(r);
        pending_rsp.push_back(typed ? typed_rsp : pred);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_rsp.size() == 0);
        repeat (4) @(posedge clk);
    endtask

    // bucket count write, only with nothing in flight
    task automatic write_bucket_count(input logic [CFG_W-1:0] n);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        bucket_mod = n;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    typedef struct {
        cmd_t        cmd;
        logic [63:0] key;
        logic [3:0]  klen;
        logic [63:0] val;
        logic [3:0]  vlen;
        bit          typed;
        status_t     st;
        logic [63:0] fv;
        logic [3:0]  fl;
        int          n;
    } dir_row_t;

    dir_row_t dir_rows [21];
    logic [63:0] pool_key [POOL_SIZE];
    logic [3:0]  pool_len [POOL_SIZE];
    logic [CFG_W-1:0] phase_mod [8];

    initial begin
        req_t        r;
        rsp_t        t;
        logic [63:0] mk;
        int          p;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        quiet       = 1'b0;
        tbl_count   = 0;
        bucket_mod  = BUCKETS_RESET;
        foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;

        // single-byte keys land in their own bucket; 0x0508.. share bucket 5
        dir_rows = '{
            '{CMD_SEARCH, 64'h41, 4'd1, 64'h0, 4'd0, 1, ST_ABSENT, 64'h0, 4'd0, 0},
            '{CMD_INSERT, 64'h41, 4'd1, 64'h1122, 4'd2, 1, ST_DONE, 64'h0, 4'd0, 1},
            '{CMD_SEARCH, 64'h41, 4'd1, 64'h0, 4'd0, 1, ST_DONE, 64'h1122, 4'd2, 1},
            '{CMD_INSERT, 64'h41, 4'd1, 64'h99, 4'd1, 1, ST_PRESENT, 64'h0, 4'd0, 1},
            '{CMD_UPDATE, 64'h41, 4'd1, '1, 4'd8, 1, ST_DONE, 64'h0, 4'd0, 1},
            '{CMD_SEARCH, 64'h41, 4'd1, 64'h0, 4'd0, 1, ST_DONE, '1, 4'd8, 1},
            '{CMD_DELETE, 64'h41, 4'd1, 64'h0, 4'd0, 1, ST_DONE, 64'h0, 4'd0, 0},
            '{CMD_DELETE, 64'h41, 4'd1, 64'h0, 4'd0, 1, ST_ABSENT, 64'h0, 4'd0, 0},
            '{CMD_UPDATE, 64'h41, 4'd1, 64'h5, 4'd1, 1, ST_ABSENT, 64'h0, 4'd0, 0},
            // empty key, bits beyond the length are ignored
            '{CMD_INSERT, 64'h0, 4'd0, 64'h77, 4'd0, 1, ST_DONE, 64'h0, 4'd0, 1},
            '{CMD_SEARCH, '1, 4'd0, 64'h0, 4'd0, 1, ST_DONE, 64'h0, 4'd0, 1},
            // lengths above eight saturate
            '{CMD_INSERT, '1, 4'd15, '1, 4'd15, 1, ST_DONE, 64'h0, 4'd0, 2},
            '{CMD_SEARCH, '1, 4'd8, 64'h0, 4'd0, 1, ST_DONE, '1, 4'd8, 2},
            // zero bytes inside the length count
            '{CMD_INSERT, 64'h0, 4'd8, 64'h0, 4'd3, 0, ST_DONE, 64'h0, 4'd0, 3},
            '{CMD_INSERT, 64'h05, 4'd1, 64'hab, 4'd1, 0, ST_DONE, 64'h0, 4'd0, 4},
            '{CMD_INSERT, 64'h0508, 4'd2, 64'hcd, 4'd1, 0, ST_DONE, 64'h0, 4'd0, 5},
            '{CMD_INSERT, 64'h0510, 4'd2, 64'hef, 4'd1, 0, ST_DONE, 64'h0, 4'd0, 6},
            '{CMD_INSERT, 64'h0518, 4'd2, 64'h12, 4'd1, 0, ST_DONE, 64'h0, 4'd0, 7},
            // fifth key of bucket 5 finds it full; present wins over full
            '{CMD_INSERT, 64'h0520, 4'd2, 64'h34, 4'd1, 1, ST_FULL, 64'h0, 4'd0, 7},
            '{CMD_INSERT, 64'h05, 4'd1, 64'h56, 4'd1, 1, ST_PRESENT, 64'h0, 4'd0, 7},
            '{CMD_SEARCH, 64'h0520, 4'd2, 64'h0, 4'd0, 1, ST_ABSENT, 64'h0, 4'd0, 7}
        };
        // zero acts as one, 511 as the full table
        phase_mod = '{9'd1, 9'd0, 9'd511, 9'd255, 9'd2, 9'd300, 9'd256, 9'd17};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_bucket_count(9'd256);
        foreach (dir_rows[i]) begin
            r.cmd          = dir_rows[i].cmd;
            r.key          = dir_rows[i].key;
            r.key_length   = dir_rows[i].klen;
            r.value        = dir_rows[i].val;
            r.value_length = dir_rows[i].vlen;
            t.status             = dir_rows[i].st;
            t.found_value        = dir_rows[i].fv;
            t.found_value_length = dir_rows[i].fl;
            t.stored_entries     = 11'(dir_rows[i].n);
            send_req(r, dir_rows[i].typed, t);
        end

        // random phases, each at its own bucket count
        foreach (phase_mod[ph]) begin
            write_bucket_count(phase_mod[ph]);
            quiet = (ph == 3);
            // fresh key pool so that lookups mostly hit
            for (int i = 0; i < POOL_SIZE; i++) begin
                pool_key[i] = {$urandom, $urandom};
                pool_len[i] = ($urandom_range(0, 9) == 9) ? 4'($urandom_range(9, 15))
                                                          : 4'($urandom_range(0, 8));
            end
            for (int n = 0; n < PHASE_LEN; n++) begin
                // once, hold off until everything in flight has come back
                if (ph == 2 && n == PHASE_LEN / 2) drain();
                r.cmd = 2'($urandom_range(0, 3));
                if ($urandom_range(0, 99) < 85) begin
                    p = $urandom_range(0, POOL_SIZE - 1);
                    mk = len_mask((pool_len[p] > 4'd8) ? 4'd8 : pool_len[p]);
                    r.key_length = pool_len[p];
                    r.key = (pool_key[p] & mk) | ({$urandom, $urandom} & ~mk);
                end else begin
                    r.key_length = 4'($urandom_range(0, 15));
                    r.key = {$urandom, $urandom};
                end
                r.value        = {$urandom, $urandom};
                r.value_length = 4'($urandom_range(0, 15));
                send_req(r, 1'b0, '0);
            end
        end
        quiet = 1'b0;

        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_rsp.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/htkv_pkg.sv
rtl/core/htkv_hash.sv
rtl/core/hash_table_key_value_store_core.sv
tb/sv/tb_top.sv
